>>> src/block_table_first_fit_allocator_top_macros.svh
// Assertion macros for the block table allocator.
// Define ASSERT_OFF to compile the assertions out.
`ifndef BLOCK_TABLE_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_TABLE_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every clock edge outside reset.
`define BTFFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block table allocator assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define BTFFA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block table allocator assertion failed");

`else

`define BTFFA_ASSERT_IMP(label, ante, cons)
`define BTFFA_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> src/btffa_pkg.sv
package btffa_pkg;

  // Heap geometry.
  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 4096;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int ADDR_W = 48;
  localparam int PAGE_W = ADDR_W - OFF_W;
  localparam int SIZE_W = 23;
  localparam int NEED_W = SIZE_W + 1 - OFF_W;
  localparam int BIU_W  = 11;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;
  localparam logic [BIU_W-1:0]     BLOCKS_RESET      = BIU_W'(1024);

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  // One table entry: bit 0 taken, bit 1 first of a run, bit 2 has-next.
  typedef struct packed {
    logic has_next;
    logic first;
    logic taken;
  } entry_t;

  // Write port of the block table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE_CHK,
    S_WALK,
    S_DONE
  } state_t;

endpackage

>>> src/block_table_first_fit_allocator_top.sv
// Allocate runs a first-fit scan of the table and then marks the found run, one table entry
// per cycle through the single read port and then the write port. Free range-checks the
// address and then releases the chain; zero-size and empty-heap allocates go straight to the result.
// One request is in flight at a time; the next is taken once the result is registered.
// Reset: synchronous; base_address clears, blocks_in_use returns to 1024, and a
// clearing pass zeroes all 1024 table entries before the first request is accepted.
`include "block_table_first_fit_allocator_top_macros.svh"

module block_table_first_fit_allocator_top (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [btffa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btffa_pkg::ADDR_W-1:0]       cfg_data,
  // Request channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic [btffa_pkg::SIZE_W-1:0]       request_size,
  input  logic [btffa_pkg::ADDR_W-1:0]       free_address,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [btffa_pkg::ADDR_W-1:0]       result_address,
  output logic [1:0]                         status
);
  import btffa_pkg::*;

  state_t             state, state_next;
  logic [PAGE_W-1:0]  base_reg;
  logic [BIU_W-1:0]   blocks_reg;
  logic [CNT_W-1:0]   n_act;

  logic [IDX_W-1:0]   clr_idx, clr_idx_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic [CNT_W-1:0]   chk_idx, chk_idx_next;
  logic               chk_vld, chk_vld_next;
  logic [CNT_W-1:0]   run, run_next;
  logic [IDX_W-1:0]   start, start_next;
  logic [CNT_W-1:0]   mk, mk_next;
  logic [NEED_W-1:0]  need, need_next;
  logic [PAGE_W-1:0]  free_pg, free_pg_next;
  logic [ADDR_W-1:0]  res_addr, res_addr_next;
  status_t            res_status, res_status_next;
  logic               out_valid_next;
  logic [ADDR_W-1:0]  result_address_next;
  logic [1:0]         status_next;

  tbl_wr_t            wr;
  entry_t             rdata;

  logic [SIZE_W:0]    size_sum;
  logic [NEED_W-1:0]  run_inc;
  logic [NEED_W-1:0]  mk_inc;
  logic [PAGE_W-1:0]  free_diff;

  btffa_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Configuration registers; writes are taken at any time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg   <= '0;
      blocks_reg <= BLOCKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_ADDRESS:  base_reg   <= cfg_data[ADDR_W-1:OFF_W];
        REG_BLOCKS_IN_USE: blocks_reg <= cfg_data[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Managed entry count, clamped to the table size.
  always_comb begin
    if (32'(blocks_reg) > 32'(NUM_BLOCKS)) begin
      n_act = CNT_W'(NUM_BLOCKS);
    end else begin
      n_act = CNT_W'(blocks_reg);
    end
  end

  // Block count of a request, rounded up.
  assign size_sum  = {1'b0, request_size} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
  assign run_inc   = NEED_W'(run) + NEED_W'(1);
  assign mk_inc    = NEED_W'(mk) + NEED_W'(1);
  assign free_diff = free_pg - base_reg;

  assign in_ready = (state == S_IDLE);

  // Next state, table port and datapath updates.
  always_comb begin
    state_next          = state;
    clr_idx_next        = clr_idx;
    rd_idx_next         = rd_idx;
    chk_idx_next        = chk_idx;
    chk_vld_next        = chk_vld;
    run_next            = run;
    start_next          = start;
    mk_next             = mk;
    need_next           = need;
    free_pg_next        = free_pg;
    res_addr_next       = res_addr;
    res_status_next     = res_status;
    out_valid_next      = out_valid && !out_ready;
    result_address_next = result_address;
    status_next         = status;
    wr                  = '0;

    case (state)
      // Zero every table entry, one per cycle.
      S_CLEAR: begin
        wr.en        = 1'b1;
        wr.addr      = clr_idx;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(NUM_BLOCKS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_addr_next = '0;
          rd_idx_next   = '0;
          chk_vld_next  = 1'b0;
          run_next      = '0;
          case (opcode)
            OP_ALLOC: begin
              need_next = size_sum[SIZE_W:OFF_W];
              if (request_size == '0 || n_act == '0) begin
                res_status_next = ST_NOMEM;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_FREE: begin
              free_pg_next = free_address[ADDR_W-1:OFF_W];
              state_next   = S_FREE_CHK;
            end
            default: ;
          endcase
        end
      end

      // First-fit scan: one read issued and one entry checked per cycle.
      S_SCAN: begin
        rd_idx_next  = rd_idx + CNT_W'(1);
        chk_idx_next = rd_idx;
        chk_vld_next = 1'b1;
        if (chk_vld) begin
          if (rdata.taken) begin
            run_next = '0;
          end else begin
            if (run == '0) begin
              start_next = chk_idx[IDX_W-1:0];
            end
            run_next = run + CNT_W'(1);
          end
          if (!rdata.taken && run_inc == need) begin
            mk_next      = '0;
            chk_vld_next = 1'b0;
            state_next   = S_MARK;
          end else if (chk_idx == n_act - CNT_W'(1)) begin
            res_status_next = ST_NOMEM;
            state_next      = S_DONE;
          end
        end
      end

      // Write the found run, one entry per cycle.
      S_MARK: begin
        wr.en            = 1'b1;
        wr.addr          = start + mk[IDX_W-1:0];
        wr.data.taken    = 1'b1;
        wr.data.first    = (mk == '0);
        wr.data.has_next = (mk_inc != need);
        mk_next          = mk + CNT_W'(1);
        if (mk_inc == need) begin
          res_addr_next   = {base_reg + PAGE_W'(start), OFF_W'(0)};
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end
      end

      // Turn the free address into a block index and range-check it.
      S_FREE_CHK: begin
        if (free_pg < base_reg || free_diff >= PAGE_W'(n_act)) begin
          res_status_next = ST_BADFREE;
          state_next      = S_DONE;
        end else begin
          rd_idx_next  = free_diff[CNT_W-1:0];
          chk_vld_next = 1'b0;
          state_next   = S_WALK;
        end
      end

      // Release the chain; reads run one entry ahead of the clearing writes.
      S_WALK: begin
        rd_idx_next  = rd_idx + CNT_W'(1);
        chk_idx_next = rd_idx;
        chk_vld_next = 1'b1;
        if (chk_vld) begin
          if (!rdata.taken) begin
            res_status_next = ST_BADFREE;
            state_next      = S_DONE;
          end else begin
            wr.en   = 1'b1;
            wr.addr = chk_idx[IDX_W-1:0];
            if (!rdata.has_next || chk_idx == n_act - CNT_W'(1)) begin
              res_status_next = ST_OK;
              state_next      = S_DONE;
            end
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next      = 1'b1;
          result_address_next = res_addr;
          status_next         = res_status;
          state_next          = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      chk_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      chk_vld   <= chk_vld_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_idx         <= rd_idx_next;
    chk_idx        <= chk_idx_next;
    run            <= run_next;
    start          <= start_next;
    mk             <= mk_next;
    need           <= need_next;
    free_pg        <= free_pg_next;
    res_addr       <= res_addr_next;
    res_status     <= res_status_next;
    result_address <= result_address_next;
    status         <= status_next;
  end

  // The run being marked lies inside the managed range.
  `BTFFA_ASSERT_IMP(a_mark_in_range, state == S_MARK, wr.en && (CNT_W'(wr.addr) < n_act))
  // The scan only reads the table.
  `BTFFA_ASSERT_IMP(a_scan_no_write, state == S_SCAN, !wr.en)
  // An accepted request always leaves the idle state.
  `BTFFA_ASSERT_NXT(a_accept_busy, in_valid && in_ready, state != S_IDLE)
  // Failures and frees report address zero.
  `BTFFA_ASSERT_IMP(a_fail_zero_addr, out_valid && (status != ST_OK), result_address == '0)

endmodule

>>> src/btffa_ram.sv
module btffa_ram (
  input  logic                                clk,
  input  btffa_pkg::tbl_wr_t                  wr,
  input  logic [btffa_pkg::IDX_W-1:0]         raddr,
  output btffa_pkg::entry_t                   rdata
);
  import btffa_pkg::*;

  entry_t mem [NUM_BLOCKS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/block_table_first_fit_allocator_top_tb.sv
module block_table_first_fit_allocator_top_tb;
  import btffa_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int ROUND_ITEMS = 95;
  localparam logic [ADDR_W-1:0] BLK = ADDR_W'(BLOCK_BYTES);

  // Shadow of the heap: block table, registers and the results still owed by the block.
  class heap_tracker;
    typedef struct packed {
      logic [ADDR_W-1:0] addr;
      status_t           st;
    } outcome_t;

    entry_t            blk_table [NUM_BLOCKS];
    logic [ADDR_W-1:0] heap_base;
    logic [BIU_W-1:0]  heap_blocks;
    outcome_t          owed_results [$];
    logic [ADDR_W-1:0] live_runs [$];
    int                mismatches;
    int                compared;
    int                grants;
    int                refusals;
    int                frees_ok;
    int                frees_bad;

    function new();
      foreach (blk_table[i]) blk_table[i] = '0;
      heap_base   = '0;
      heap_blocks = BLOCKS_RESET;
      mismatches  = 0;
      compared    = 0;
      grants      = 0;
      refusals    = 0;
      frees_ok    = 0;
      frees_bad   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      if (idx == REG_BASE_ADDRESS) begin
        heap_base = data;
      end else begin
        heap_blocks = data[BIU_W-1:0];
      end
      // Addresses handed out under the old setting no longer mean the same runs.
      live_runs.delete();
    endfunction

    function int unsigned active_blocks();
      return (heap_blocks > NUM_BLOCKS) ? NUM_BLOCKS : heap_blocks;
    endfunction

    function logic [ADDR_W-1:0] aligned_base();
      return heap_base & ~(BLK - 1);
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // First-fit search for a run of free entries, then marking of the run.
    function outcome_t predict_alloc(logic [SIZE_W-1:0] size);
      outcome_t    r;
      int unsigned need;
      int unsigned run;
      int unsigned start;
      int unsigned n;
      int unsigned i;
      bit          found;
      r.addr = '0;
      r.st   = ST_NOMEM;
      run    = 0;
      start  = 0;
      found  = 1'b0;
      if (size == '0) return r;
      need = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      n    = active_blocks();
      for (i = 0; i < n && !found; i++) begin
        if (blk_table[i].taken) begin
          run = 0;
        end else begin
          if (run == 0) start = i;
          run++;
          if (run == need) found = 1'b1;
        end
      end
      if (!found) return r;
      for (i = 0; i < need; i++) begin
        blk_table[start + i].taken    = 1'b1;
        blk_table[start + i].first    = (i == 0);
        blk_table[start + i].has_next = (i + 1 < need);
      end
      r.addr = aligned_base() + ADDR_W'(start) * BLK;
      r.st   = ST_OK;
      live_runs.push_back(r.addr);
      return r;
    endfunction

    // Release walk: clear entries until one without has-next or the range end, stop on a free entry.
    function status_t predict_free(logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] base_a;
      logic [ADDR_W-1:0] offset;
      int unsigned       n;
      int unsigned       idx;
      entry_t            e;
      base_a = aligned_base();
      n      = active_blocks();
      if (addr < base_a) return ST_BADFREE;
      offset = (addr - base_a) >> OFF_W;
      if (offset >= ADDR_W'(n)) return ST_BADFREE;
      for (idx = int'(offset); idx < n; idx++) begin
        e = blk_table[idx];
        if (!e.taken) return ST_BADFREE;
        blk_table[idx] = '0;
        if (!e.has_next) break;
      end
      return ST_OK;
    endfunction

    // Called once per accepted request transaction.
    function void note_request(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
      outcome_t r;
      if (op == OP_ALLOC) begin
        r = predict_alloc(size);
        if (r.st == ST_OK) grants++;
        else refusals++;
      end else begin
        r.addr = '0;
        r.st   = predict_free(addr);
        if (r.st == ST_OK) frees_ok++;
        else frees_bad++;
      end
      owed_results.push_back(r);
    endfunction

    function void report(string what, logic [ADDR_W-1:0] exp_v, logic [ADDR_W-1:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
      end
    endfunction

    // Called once per accepted result transaction.
    function void check_result(logic [ADDR_W-1:0] addr, logic [1:0] st);
      outcome_t exp_r;
      if (owed_results.size() == 0) begin
        report("unexpected result", '0, addr);
        return;
      end
      exp_r = owed_results.pop_front();
      compared++;
      if (addr !== exp_r.addr) report("result_address", exp_r.addr, addr);
      if (st !== exp_r.st) report("status", ADDR_W'(exp_r.st), ADDR_W'(st));
    endfunction
  endclass

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [ADDR_W-1:0]     cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  opcode         = OP_ALLOC;
  logic [SIZE_W-1:0]     request_size   = '0;
  logic [ADDR_W-1:0]     free_address   = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [ADDR_W-1:0]     result_address;
  logic [1:0]            status;

  heap_tracker tracker = new();
  int          send_idle_pct = 21;
  int          recv_idle_pct = 56;
  int          reg_writes    = 0;
  int          cycle_count   = 0;
  bit          hold_pending  = 1'b0;

  block_table_first_fit_allocator_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .request_size   (request_size),
    .free_address   (free_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_address (result_address),
    .status         (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure and checking of every result transaction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) tracker.check_result(result_address, status);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    reg_writes++;
  endtask

  // Both registers, written back to back; only called with nothing in flight.
  task automatic set_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] blocks_word);
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_BLOCKS_IN_USE, blocks_word);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until every owed result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // One request transaction, preceded by random idle cycles and sometimes a full drain.
  task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr);
    bit hold;
    hold = hold_pending || ($urandom_range(0, 59) == 0);
    hold_pending = 1'b0;
    forever begin
      if (!(hold && tracker.pending() != 0)) begin
        if ($urandom_range(0, 99) >= send_idle_pct) break;
      end
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    request_size <= size;
    free_address <= addr;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(op, size, addr);
  endtask

  task automatic alloc_req(input logic [SIZE_W-1:0] size);
    send_request(OP_ALLOC, size, rand48());
  endtask

  task automatic free_req(input logic [ADDR_W-1:0] addr);
    send_request(OP_FREE, SIZE_W'($urandom), addr);
  endtask

  // Mostly allocations and frees of live runs, with some stray frees mixed in.
  task automatic random_request();
    int unsigned       roll;
    int unsigned       pick;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              op;
    roll = $urandom_range(0, 99);
    size = SIZE_W'($urandom);
    addr = rand48();
    if (roll < 50 || (roll < 85 && tracker.live_runs.size() == 0)) begin
      op = OP_ALLOC;
      case ($urandom_range(0, 19))
        0:       size = '0;
        1:       size = SIZE_W'($urandom);
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                 size = SIZE_W'($urandom_range(1, 4 * BLOCK_BYTES));
        default: size = SIZE_W'($urandom_range(1, 24 * BLOCK_BYTES));
      endcase
    end else if (roll < 85) begin
      op   = OP_FREE;
      pick = $urandom_range(0, tracker.live_runs.size() - 1);
      addr = tracker.live_runs[pick];
      tracker.live_runs.delete(pick);
      // Sometimes an unaligned address, sometimes the second block of the run.
      case ($urandom_range(0, 7))
        0:       addr = addr + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1));
        1:       addr = addr + BLK;
        default: ;
      endcase
    end else begin
      op = OP_FREE;
      if ($urandom_range(0, 1) == 1) begin
        addr = tracker.aligned_base()
             + ADDR_W'($urandom_range(0, tracker.active_blocks() + 3)) * BLK;
      end
    end
    send_request(op, size, addr);
  endtask

  initial begin
    int unsigned       round_blocks [6];
    logic [ADDR_W-1:0] base;
    round_blocks = '{48, 1024, 6, 256, 1024, 20};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero-size request, small runs, runs that cannot fit.
    alloc_req('0);
    alloc_req(SIZE_W'(1));
    alloc_req(SIZE_W'(BLOCK_BYTES));
    alloc_req(SIZE_W'(BLOCK_BYTES + 1));
    alloc_req(SIZE_W'(NUM_BLOCKS * BLOCK_BYTES));
    alloc_req({SIZE_W{1'b1}});
    // Unaligned free, double free, free of an inner block, walk into a free entry.
    free_req(BLK + 48'd123);
    free_req(BLK);
    free_req(3 * BLK);
    free_req(2 * BLK);
    // Indexes past the active range.
    free_req(ADDR_W'(NUM_BLOCKS) * BLK);
    free_req({ADDR_W{1'b1}});

    // Base at the top of the address space with a count above the table size.
    settle();
    set_config(48'hFFFF_FFFF_F7FF, ADDR_W'(2047));
    alloc_req(SIZE_W'(2 * BLOCK_BYTES));
    free_req(48'h0000_0000_0FFF);
    free_req(48'hFFFF_FFFF_F000);

    // A run that fills the heap, then a shorter heap so the chain runs off its end.
    settle();
    set_config(48'h5000, ADDR_W'(8));
    free_req(48'h6000);
    alloc_req(SIZE_W'(8 * BLOCK_BYTES));
    settle();
    set_config(48'h5000, ADDR_W'(4));
    free_req(48'h5000);

    // Single-block heap, then an empty one.
    settle();
    set_config(48'h5000, ADDR_W'(1));
    alloc_req(SIZE_W'(1));
    alloc_req(SIZE_W'(1));
    free_req(48'h6000);
    settle();
    set_config(48'h5000, ADDR_W'(0));
    alloc_req(SIZE_W'(1));
    free_req(48'h5000);

    // Random rounds, two heap settings under each idling mode.
    hold_pending = 1'b1;
    for (int r = 0; r < 6; r++) begin
      case (r / 2)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      base = (r == 0) ? {ADDR_W{1'b1}} : rand48();
      settle();
      set_config(base, (rand48() & ~ADDR_W'(12'h7FF)) | ADDR_W'(round_blocks[r]));
      for (int k = 0; k < ROUND_ITEMS; k++) random_request();
    end

    settle();
    repeat (50) @(posedge clk);

    $display("Requests: %0d allocations granted, %0d refused, %0d frees accepted, %0d rejected.",
             tracker.grants, tracker.refusals, tracker.frees_ok, tracker.frees_bad);
    $display("%0d results compared over %0d register writes, %0d mismatches, %0d left owed.",
             tracker.compared, reg_writes, tracker.mismatches, tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
